// ----- src/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes for the bounded double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // operation carried in the input word's tuser
  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  // result status carried in the output word's tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // fixed field widths of the stream channels
  localparam int FUNC_BITS     = 2;
  localparam int PUSH_BITS     = 32;
  localparam int POP_BITS      = 32;
  localparam int STATUS_BITS   = 2;
  localparam int FILL_BITS     = 9;
  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 48;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - POP_BITS - FILL_BITS;

  // control from the pointer unit to the ring and result stage
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } dq_ctl_t;

endpackage

`default_nettype wire

// ----- src/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// front pointer and element count, ring addressing and status decode
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            op_acc,
  input  wire dq_pkg::func_t   func,
  output dq_pkg::dq_ctl_t      ctl,
  output logic      [AW-1:0]   wr_addr,
  output logic      [AW-1:0]   rd_addr,
  output logic      [CW-1:0]   count_nxt
);

  import dq_pkg::*;

  localparam int SW = CW + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r;
  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc;
  logic [SW-1:0] tail_sum, last_sum;
  logic [AW-1:0] tail_pos, last_pos;

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);

  // head + count, below twice the capacity, and head + count - 1, which wraps when empty with head zero
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign last_sum = tail_sum - SW'(1);

  always_comb begin
    logic [SW-1:0] t, l;
    t = (tail_sum >= SW'(CAPACITY)) ? tail_sum - SW'(CAPACITY) : tail_sum;
    l = (last_sum >= SW'(CAPACITY)) ? last_sum - SW'(CAPACITY) : last_sum;
    tail_pos = t[AW-1:0];
    last_pos = l[AW-1:0];
  end

  always_comb begin
    ctl.wr_en  = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.status = ST_OK;
    wr_addr    = tail_pos;
    rd_addr    = last_pos;
    head_nxt   = head_r;
    count_nxt  = count_r;
    unique case (func) inside
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en = op_acc;
          count_nxt = count_r + CW'(1);
          if (func == FUNC_PUSH_FRONT) begin
            head_nxt = head_dec;
            wr_addr  = head_dec;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.rd_en = op_acc;
          count_nxt = count_r - CW'(1);
          if (func == FUNC_POP_FRONT) begin
            head_nxt = head_inc;
            rd_addr  = head_r;
          end
        end
      end
      default: begin
        ctl.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (op_acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(CAPACITY - 1))
    else $error("front pointer outside the ring");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_en && ctl.rd_en))
    else $error("read and write issued together");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    op_acc && ctl.status == ST_FULL |=> count_r == $past(count_r) && head_r == $past(head_r))
    else $error("dropped push changed the state");

endmodule

`default_nettype wire

// ----- src/bounded_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// fixed-capacity deque on a ring ram, one operation word in, one result out
// ----------------------------------------------------------------------------
// usage
//   in_*  : one operation per word; in_tuser selects push front, push back,
//           pop front or pop back, in_tdata carries the word to push
//   out_* : one result word per operation, in order; in_tuser-style status in
//           out_tuser (ok, pop on empty, push on full), popped word and the
//           fill count after the operation in out_tdata
//   result: valid in the cycle after the operation is taken
//   throughput: one operation per cycle unless the result is held; each touches
//           at most one ring entry, a push writes the ram at acceptance, a pop
//           reads it through the ram's registered read port straight into the result stage
//   reset: front pointer and count cleared, result stage empty; the ring
//           contents are left as they are and need no clearing pass
//   stall: a held result keeps the ram read register and the status stage
//           still; a new operation is taken in the cycle the result leaves
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input operation channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [dq_pkg::IN_TDATA_BITS-1:0]   in_tdata,  // [31:0] push_word
  input  wire logic [dq_pkg::FUNC_BITS-1:0]       in_tuser,  // [1:0] func
  // result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [dq_pkg::OUT_TDATA_BITS-1:0]  out_tdata, // [31:0] pop_word, [40:32] fill_count
  output logic      [dq_pkg::STATUS_BITS-1:0]     out_tuser  // [1:0] status
);

  import dq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic           in_acc;
  dq_ctl_t        ctl;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [CW-1:0]  count_nxt;
  logic [63:0]    push_wide;
  logic [63:0]    pop_wide;
  logic [31:0]    count_wide;
  logic [WORD_BITS-1:0] ram_rd_data;

  // result stage
  logic                 out_valid_r;
  logic                 pop_ok_r;
  status_t              status_r;
  logic [FILL_BITS-1:0] fill_r;
  logic [POP_BITS-1:0]  pop_word;

  // one-slot result stage, refilled in the cycle it drains
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  dq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_acc    (in_acc),
    .func      (func_t'(in_tuser)),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .count_nxt (count_nxt)
  );

  // stored word keeps its low WORD_BITS bits
  assign push_wide = {32'd0, in_tdata};

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_wide[WORD_BITS-1:0]),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign count_wide = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
    // payload of the result stage, no reset needed
    if (in_acc) begin
      pop_ok_r <= ctl.rd_en;
      status_r <= ctl.status;
      fill_r   <= count_wide[FILL_BITS-1:0];
    end
  end

  // popped word comes straight from the ram read register
  assign pop_wide = 64'(ram_rd_data);
  assign pop_word = pop_ok_r ? pop_wide[POP_BITS-1:0] : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_BITS{1'b0}}, fill_r, pop_word};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

// ----- test/bounded_double_ended_queue_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// self-checking bench for the ring-buffer deque: every operation word sent in
// is applied to a local deque, and each result word is compared field by
// field with the oldest prediction; random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounded_double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH     = 256;
  localparam int DATA_BITS = 32;

  // one predicted result word, split into its fields
  typedef struct {
    logic [POP_BITS-1:0]  pop_word;
    status_t              status;
    logic [FILL_BITS-1:0] fill;
  } dq_result_t;

  logic clk;
  logic rst_n;

  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [31:0] push_word
  logic [FUNC_BITS-1:0]      in_tuser;   // [1:0] func
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [31:0] pop_word, [40:32] fill_count
  logic [STATUS_BITS-1:0]    out_tuser;  // [1:0] status

  // local copy of the deque: ring, front pointer and occupancy
  logic [DATA_BITS-1:0] ring_mem [DEPTH];
  logic [7:0]           front_ptr;
  logic [8:0]           occupancy;

  // results predicted but not yet seen, oldest first
  dq_result_t pending_results [$];

  int  error_count;
  bit  src_gaps_on;        // sender draws a gap before each word
  bit  sink_gaps_on;       // receiver draws a stall before each word
  int  sink_hold_cycles;   // one-off long back-pressure request

  bounded_double_ended_queue #(
    .CAPACITY  (DEPTH),
    .WORD_BITS (DATA_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // apply one operation to the local deque and return the result it gives
  function automatic dq_result_t deque_apply(input func_t op,
                                             input logic [DATA_BITS-1:0] word);
    dq_result_t r;
    logic [7:0] slot;
    r.pop_word = '0;
    r.status   = ST_OK;
    if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK) begin
      if (occupancy == DEPTH) begin
        // full: word dropped, nothing moves
        r.status = ST_FULL;
      end else begin
        if (op == FUNC_PUSH_FRONT) begin
          front_ptr = front_ptr - 8'd1;   // wraps 0 -> 255
          slot      = front_ptr;
        end else begin
          slot = front_ptr + occupancy[7:0];
        end
        ring_mem[slot] = word;
        occupancy      = occupancy + 9'd1;
      end
    end else begin
      if (occupancy == 0) begin
        // empty: zero word, nothing moves
        r.status = ST_EMPTY;
      end else begin
        if (op == FUNC_POP_FRONT) begin
          slot      = front_ptr;
          front_ptr = front_ptr + 8'd1;
        end else begin
          slot = front_ptr + 8'(occupancy - 9'd1);
        end
        r.pop_word = ring_mem[slot];
        occupancy  = occupancy - 9'd1;
      end
    end
    r.fill = occupancy;
    return r;
  endfunction

  // offer one operation word and wait for it to be taken; the prediction is
  // made at the accepting edge so it lines up with the block's own order
  task automatic send_op(input func_t op, input logic [DATA_BITS-1:0] word);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    @(posedge clk iff in_tready);
    pending_results.push_back(deque_apply(op, word));
  endtask

  // pick a push or a pop, either end, with push_pct percent pushes
  function automatic func_t pick_op(input int push_pct);
    bit push;
    bit at_back;
    push    = ($urandom_range(0, 99) < push_pct);
    at_back = ($urandom_range(0, 1) != 0);
    if (push) return at_back ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    return at_back ? FUNC_POP_BACK : FUNC_POP_FRONT;
  endfunction

  // receiver: stall drawn per word, plus any long hold that a test asks for;
  // ready is only ever lowered once and raised once per stall
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = sink_gaps_on ? $urandom_range(0, 9) : 0;
      if (sink_hold_cycles > 0) begin
        stall            = stall + sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  // result checker: every accepted word against the oldest prediction
  always @(posedge clk) begin : result_check
    dq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.pop_word)
          report_mismatch("pop_word", 48'(out_tdata[31:0]), 48'(want.pop_word));
        if (out_tuser !== want.status)
          report_mismatch("status", 48'(out_tuser), 48'(want.status));
        if (out_tdata[40:32] !== want.fill)
          report_mismatch("fill_count", 48'(out_tdata[40:32]), 48'(want.fill));
      end
    end
  end

  // extremes of the data word, both empty pops, both pointer wraps
  task automatic test_directed();
    send_op(FUNC_POP_FRONT,  32'h0000_0000);  // empty, front end
    send_op(FUNC_POP_BACK,   32'hFFFF_FFFF);  // empty, back end
    send_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);  // front pointer wraps below zero
    send_op(FUNC_PUSH_BACK,  32'h0000_0000);  // back slot wraps past the top
    send_op(FUNC_PUSH_FRONT, 32'hA5A5_A5A5);
    send_op(FUNC_PUSH_BACK,  32'h5A5A_5A5A);
    send_op(FUNC_POP_BACK,   32'hFFFF_FFFF);
    send_op(FUNC_POP_FRONT,  32'h0000_0000);
    send_op(FUNC_POP_FRONT,  32'h1234_5678);
    send_op(FUNC_POP_BACK,   32'h0000_0000);
    send_op(FUNC_POP_BACK,   32'h0000_0000);  // empty again
    send_op(FUNC_PUSH_BACK,  32'h8000_0000);
    send_op(FUNC_PUSH_BACK,  32'h0000_0001);
    send_op(FUNC_POP_FRONT,  32'h0000_0000);  // front pointer steps up from zero
    send_op(FUNC_POP_FRONT,  32'h0000_0000);
    send_op(FUNC_POP_FRONT,  32'h0000_0000);
    send_op(FUNC_PUSH_FRONT, 32'h1234_5678);
    send_op(FUNC_POP_BACK,   32'hFFFF_FFFF);
    send_op(FUNC_PUSH_BACK,  32'hDEAD_BEEF);
    send_op(FUNC_POP_FRONT,  32'h0000_0000);
  endtask

  // fill to capacity from random ends, push on full at both ends, drain, then pop on empty at both ends
  task automatic test_fill_and_drain();
    while (occupancy < DEPTH) send_op(pick_op(100), $urandom);
    send_op(FUNC_PUSH_FRONT, $urandom);
    send_op(FUNC_PUSH_BACK,  $urandom);
    send_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH_BACK,  32'h0000_0000);
    while (occupancy > 0) send_op(pick_op(0), $urandom);
    send_op(FUNC_POP_BACK,  $urandom);
    send_op(FUNC_POP_FRONT, $urandom);
  endtask

  // receiver holds off for a long stretch while words keep coming back to back
  task automatic test_backpressure();
    src_gaps_on      = 1'b0;
    sink_gaps_on     = 1'b0;
    sink_hold_cycles = 200;
    repeat (60) send_op(pick_op(60), $urandom);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // random stretches, each push-heavy, pop-heavy or balanced, so the fill
  // level sweeps between empty and full; a few words are plain noise
  task automatic test_random(input int n_ops);
    int sent;
    int stretch;
    int push_pct;
    sent = 0;
    while (sent < n_ops) begin
      stretch      = $urandom_range(50, 250);
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (stretch) begin
        if ($urandom_range(0, 19) == 0)
          send_op(func_t'($urandom_range(0, 3)), $urandom);
        else
          send_op(pick_op(push_pct), $urandom);
        sent++;
      end
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // main sequence
  initial begin : stimulus
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    in_tuser         <= FUNC_PUSH_FRONT;
    rst_n            <= 1'b0;
    error_count      = 0;
    src_gaps_on      = 1'b1;
    sink_gaps_on     = 1'b1;
    sink_hold_cycles = 0;
    front_ptr        = '0;
    occupancy        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random(1200);

    // stop offering, let every result come home, then a short settle
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
src/dq_pkg.sv
src/dq_ram.sv
src/dq_ctrl.sv
src/bounded_double_ended_queue.sv
test/bounded_double_ended_queue_tb.sv
